[sv/sed_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sed_pkg;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_END        = 2'd1,
    KIND_NULL_OCTAL = 2'd2,
    KIND_BAD_ESCAPE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } res_t;

  localparam logic [7:0] CH_N       = 8'd110;
  localparam logic [7:0] CH_R       = 8'd114;
  localparam logic [7:0] CH_T       = 8'd116;
  localparam logic [7:0] CH_BSLASH  = 8'd92;
  localparam logic [7:0] CH_QUOTE   = 8'd34;
  localparam logic [7:0] CH_APOS    = 8'd39;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_TAB   = 8'd9;
  localparam logic [7:0] CH_BELOW_0 = 8'd47;
  localparam logic [7:0] CH_ABOVE_9 = 8'd58;

  localparam int unsigned RES_SLOTS = 3;

  function automatic res_t mk_res(logic [7:0] data, kind_t kind, logic last);
    res_t r;
    r.data = data;
    r.kind = kind;
    r.last = last;
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/sed_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

[sv/sed_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       out_last;

  modport source (output valid, output out_byte, output kind, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input kind, input out_last,
                  output ready);
endinterface
`default_nettype wire

[sv/string_escape_decoder_top.sv]
// An accepted input word is registered in the input register; its results are
// then loaded into the result slots. Throughput: one input word per cycle while
// each word yields at most one result and out_ch.ready is high; a word yielding
// more holds the input register while the three-slot shifter drains one per ready cycle.
// Reset: synchronous, active-low rst_n clears valids and all escape state.
`timescale 1ns / 1ps
`default_nettype none
module string_escape_decoder_top
  import sed_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  sed_in_if.sink     in_ch,
  sed_out_if.source  out_ch
);

  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       last_r;

  logic       esc_r, esc_nxt;
  logic [1:0] dc_r, dc_nxt;
  logic [8:0] acc_r, acc_nxt;
  logic       stop_r, stop_nxt;
  logic       err_r, err_nxt;

  res_t       slot_r [RES_SLOTS];
  logic [1:0] cnt_r;

  res_t       rs [4];
  logic [1:0] n;

  logic       pop;
  logic       advance;
  logic       dig;

  assign pop     = (cnt_r != 2'd0) && out_ch.ready;
  assign advance = in_vld_r && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready));
  assign in_ch.ready = !in_vld_r || advance;

  assign out_ch.valid    = (cnt_r != 2'd0);
  assign out_ch.out_byte = slot_r[0].data;
  assign out_ch.kind     = slot_r[0].kind;
  assign out_ch.out_last = slot_r[0].last;

  assign dig = (byte_r > CH_BELOW_0) && (byte_r < CH_ABOVE_9);

  always_comb begin
    esc_nxt  = esc_r;
    dc_nxt   = dc_r;
    acc_nxt  = acc_r;
    stop_nxt = stop_r;
    err_nxt  = err_r;
    n        = 2'd0;
    for (int i = 0; i < 4; i++) begin
      rs[i] = '0;
    end

    if (!err_nxt) begin
      if (!esc_nxt) begin
        if (byte_r == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else begin
          rs[n] = mk_res(byte_r, KIND_DATA, 1'b0);
          n = n + 2'd1;
        end
      end else if (dc_nxt != 2'd0) begin
        if (dig) begin
          if (!stop_nxt) begin
            if (!byte_r[3]) acc_nxt = {acc_nxt[5:0], byte_r[2:0]};
            else            stop_nxt = 1'b1;
          end
          dc_nxt = dc_nxt + 2'd1;
          if (dc_nxt == 2'd3) begin
            if (acc_nxt == 9'd0) begin
              rs[n] = mk_res(8'd0, KIND_NULL_OCTAL, 1'b0);
              err_nxt = 1'b1;
            end else begin
              rs[n] = mk_res(acc_nxt[7:0], KIND_DATA, 1'b0);
            end
            n = n + 2'd1;
            esc_nxt  = 1'b0;
            dc_nxt   = 2'd0;
            acc_nxt  = 9'd0;
            stop_nxt = 1'b0;
          end
        end else begin
          if (acc_nxt == 9'd0) begin
            rs[n] = mk_res(8'd0, KIND_NULL_OCTAL, 1'b0);
            err_nxt = 1'b1;
          end else begin
            rs[n] = mk_res(acc_nxt[7:0], KIND_DATA, 1'b0);
          end
          n = n + 2'd1;
          esc_nxt  = 1'b0;
          dc_nxt   = 2'd0;
          acc_nxt  = 9'd0;
          stop_nxt = 1'b0;
          if (!err_nxt) begin
            if (byte_r == CH_BSLASH) begin
              esc_nxt = 1'b1;
            end else begin
              rs[n] = mk_res(byte_r, KIND_DATA, 1'b0);
              n = n + 2'd1;
            end
          end
        end
      end else if (dig) begin
        if (!stop_nxt) begin
          if (!byte_r[3]) acc_nxt = {acc_nxt[5:0], byte_r[2:0]};
          else            stop_nxt = 1'b1;
        end
        dc_nxt = 2'd1;
      end else begin
        unique case (byte_r)
          CH_N: begin
            rs[n] = mk_res(BYTE_LF, KIND_DATA, 1'b0);
            n = n + 2'd1;
          end
          CH_R: begin
            rs[n] = mk_res(BYTE_CR, KIND_DATA, 1'b0);
            n = n + 2'd1;
          end
          CH_T: begin
            rs[n] = mk_res(BYTE_TAB, KIND_DATA, 1'b0);
            n = n + 2'd1;
          end
          CH_QUOTE, CH_BSLASH: begin
            rs[n] = mk_res(CH_BSLASH, KIND_DATA, 1'b0);
            n = n + 2'd1;
            rs[n] = mk_res(byte_r, KIND_DATA, 1'b0);
            n = n + 2'd1;
          end
          CH_APOS: begin
            rs[n] = mk_res(CH_APOS, KIND_DATA, 1'b0);
            n = n + 2'd1;
          end
          default: begin
            rs[n] = mk_res(8'd0, KIND_BAD_ESCAPE, 1'b0);
            n = n + 2'd1;
            err_nxt = 1'b1;
          end
        endcase
        esc_nxt  = 1'b0;
        dc_nxt   = 2'd0;
        acc_nxt  = 9'd0;
        stop_nxt = 1'b0;
      end
    end

    if (last_r) begin
      // short octal still open at end of string
      if (!err_nxt && esc_nxt && (dc_nxt != 2'd0)) begin
        if (acc_nxt == 9'd0) begin
          rs[n] = mk_res(8'd0, KIND_NULL_OCTAL, 1'b0);
        end else begin
          rs[n] = mk_res(acc_nxt[7:0], KIND_DATA, 1'b0);
        end
        n = n + 2'd1;
      end
      rs[n] = mk_res(8'd0, KIND_END, 1'b1);
      n = n + 2'd1;
      esc_nxt  = 1'b0;
      dc_nxt   = 2'd0;
      acc_nxt  = 9'd0;
      stop_nxt = 1'b0;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.in_byte;
      last_r <= in_ch.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= 1'b0;
      dc_r   <= 2'd0;
      acc_r  <= 9'd0;
      stop_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (advance) begin
      esc_r  <= esc_nxt;
      dc_r   <= dc_nxt;
      acc_r  <= acc_nxt;
      stop_r <= stop_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (advance) begin
      cnt_r <= n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < RES_SLOTS; i++) begin
        slot_r[i] <= rs[i];
      end
    end else if (pop) begin
      for (int i = 0; i < RES_SLOTS - 1; i++) begin
        slot_r[i] <= slot_r[i + 1];
      end
    end
  end

endmodule
`default_nettype wire

[sv/sed_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module sed_chk
  import sed_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire [1:0] out_kind,
  input wire       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
                                $stable(out_kind) && $stable(out_last))
    else $error("result word changed while stalled");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind == KIND_END)))
    else $error("out_last does not match end result");

  a_nondata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_DATA) |-> (out_byte == 8'd0))
    else $error("non-data result carries a byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind string_escape_decoder_top sed_chk u_sed_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_kind  (out_ch.kind),
  .out_last  (out_ch.out_last)
);
`default_nettype wire

[verif/tb_string_escape_decoder_top.sv]
`timescale 1ns / 1ps
module tb_string_escape_decoder_top;
  import sed_pkg::*;

  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 16;
  localparam int PREDICT     = -1;

  localparam logic [7:0] CH_DIGIT_0 = 8'd48;
  localparam logic [7:0] CH_DIGIT_8 = 8'd56;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_Q       = 8'd113;
  localparam logic [7:0] CH_X       = 8'd120;

  localparam res_t R_NONE = '{8'd0, KIND_DATA, 1'b0};
  localparam res_t R_END  = '{8'd0, KIND_END, 1'b1};

  typedef struct {
    bit                   typed;
    int                   n;
    res_t [RES_SLOTS-1:0] r;
  } word_note_t;

  typedef struct {
    logic [7:0] b;
    logic       l;
    word_note_t note;
  } dir_row_t;

  logic clk;
  logic rst_n;

  sed_in_if  in_ch();
  sed_out_if out_ch();

  string_escape_decoder_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  res_t       exp_q[$];
  word_note_t note_q[$];
  dir_row_t   dir_rows[$];
  word_note_t no_note;

  int errors;
  int cycles;
  int live_words;
  int tx_idle_pct;
  int rx_stall_pct;
  bit hold_req;

  // decoder state
  logic                 esc_open;
  logic [1:0]           n_digits;
  logic [8:0]           oct_val;
  logic                 oct_stop;
  logic                 str_err;
  res_t [RES_SLOTS-1:0] dec_res;
  int                   dec_n;

  task automatic emit(input logic [7:0] d, input kind_t k, input logic l);
    if (dec_n < RES_SLOTS) begin
      dec_res[dec_n] = '{d, k, l};
      dec_n++;
    end
  endtask

  task automatic clear_esc();
    esc_open = 1'b0;
    n_digits = 2'd0;
    oct_val  = 9'd0;
    oct_stop = 1'b0;
  endtask

  task automatic take_digit(input logic [7:0] b);
    if (!oct_stop) begin
      if (b < CH_DIGIT_8) begin
        oct_val = (oct_val << 3) + {1'b0, b - CH_DIGIT_0};
      end else begin
        oct_stop = 1'b1;
      end
    end
  endtask

  task automatic close_octal();
    if (oct_val == 9'd0) begin
      emit(8'd0, KIND_NULL_OCTAL, 1'b0);
      str_err = 1'b1;
    end else begin
      emit(oct_val[7:0], KIND_DATA, 1'b0);
    end
    clear_esc();
  endtask

  task automatic pass_plain(input logic [7:0] b);
    if (b == CH_BSLASH) begin
      esc_open = 1'b1;
    end else begin
      emit(b, KIND_DATA, 1'b0);
    end
  endtask

  task automatic decode_word(input logic [7:0] b, input logic l);
    bit is_digit;
    is_digit = (b > CH_BELOW_0) && (b < CH_ABOVE_9);
    dec_n = 0;
    if (!str_err || l) live_words++;
    if (!str_err) begin
      if (!esc_open) begin
        pass_plain(b);
      end else if (n_digits != 2'd0) begin
        if (is_digit) begin
          take_digit(b);
          n_digits = n_digits + 2'd1;
          if (n_digits == 2'd3) close_octal();
        end else begin
          // short octal: value first, then the byte as plain text
          close_octal();
          if (!str_err) pass_plain(b);
        end
      end else if (is_digit) begin
        take_digit(b);
        n_digits = 2'd1;
      end else begin
        case (b)
          CH_N: emit(BYTE_LF, KIND_DATA, 1'b0);
          CH_R: emit(BYTE_CR, KIND_DATA, 1'b0);
          CH_T: emit(BYTE_TAB, KIND_DATA, 1'b0);
          CH_QUOTE, CH_BSLASH: begin
            emit(CH_BSLASH, KIND_DATA, 1'b0);
            emit(b, KIND_DATA, 1'b0);
          end
          CH_APOS: emit(CH_APOS, KIND_DATA, 1'b0);
          default: begin
            emit(8'd0, KIND_BAD_ESCAPE, 1'b0);
            str_err = 1'b1;
          end
        endcase
        clear_esc();
      end
    end
    if (l) begin
      if (!str_err && esc_open && n_digits != 2'd0) close_octal();
      emit(8'd0, KIND_END, 1'b1);
      clear_esc();
      str_err = 1'b0;
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic l, input int n,
                         input res_t r0, input res_t r1, input res_t r2);
    dir_row_t row;
    row.b          = b;
    row.l          = l;
    row.note.typed = (n >= 0);
    row.note.n     = n;
    row.note.r     = {r2, r1, r0};
    dir_rows.push_back(row);
  endtask

  task automatic send_word(input logic [7:0] b, input logic l, input word_note_t note);
    note_q.push_back(note);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    do @(posedge clk); while (!in_ch.ready);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random_string();
    logic [7:0] s[$];
    logic [7:0] b;
    int         ntok;
    int         pick;
    int         nd;
    ntok = $urandom_range(1, 6);
    repeat (ntok) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        b = 8'($urandom_range(255));
        if (b == CH_BSLASH) b = 8'hFF;
        s.push_back(b);
      end else if (pick < 55) begin
        s.push_back(CH_BSLASH);
        case ($urandom_range(5))
          0:       s.push_back(CH_N);
          1:       s.push_back(CH_R);
          2:       s.push_back(CH_T);
          3:       s.push_back(CH_QUOTE);
          4:       s.push_back(CH_BSLASH);
          default: s.push_back(CH_APOS);
        endcase
      end else if (pick < 82) begin
        s.push_back(CH_BSLASH);
        nd = $urandom_range(1, 3);
        repeat (nd) begin
          if ($urandom_range(9) < 8) b = CH_DIGIT_0 + 8'($urandom_range(7));
          else b = CH_DIGIT_8 + 8'($urandom_range(1));
          s.push_back(b);
        end
      end else if (pick < 90) begin
        s.push_back(CH_BSLASH);
        s.push_back(8'($urandom_range(255)));
      end else begin
        s.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(9) == 0) s.push_back(CH_BSLASH);
    foreach (s[i]) send_word(s[i], (i == s.size() - 1), no_note);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int hold_cnt;
    hold_cnt     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        out_ch.ready <= 1'b0;
        hold_cnt--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    word_note_t note;
    res_t       want;
    if (!rst_n) begin
      clear_esc();
      str_err = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: byte=%0d kind=%0d last=%0d", $time,
                   out_ch.out_byte, out_ch.kind, out_ch.out_last);
        end else begin
          want = exp_q.pop_front();
          if (out_ch.out_byte !== want.data || out_ch.kind !== want.kind ||
              out_ch.out_last !== want.last) begin
            errors++;
            $display("%0t: mismatch: expected byte=%0d kind=%0d last=%0d, got byte=%0d kind=%0d last=%0d",
                     $time, want.data, want.kind, want.last,
                     out_ch.out_byte, out_ch.kind, out_ch.out_last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        note = note_q.pop_front();
        decode_word(in_ch.in_byte, in_ch.in_last);
        if (note.typed) begin
          for (int i = 0; i < note.n; i++) exp_q.push_back(note.r[i]);
        end else begin
          for (int i = 0; i < dec_n; i++) exp_q.push_back(dec_res[i]);
        end
      end
    end
  end

  initial begin
    int target;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.in_last = 1'b0;
    no_note.typed = 1'b0;
    no_note.n     = 0;
    no_note.r     = '0;

    // plain bytes at the extremes
    add_row(CH_UPPER_A, 1'b0, 1, '{CH_UPPER_A, KIND_DATA, 1'b0}, R_NONE, R_NONE);
    add_row(8'h00, 1'b0, 1, '{8'h00, KIND_DATA, 1'b0}, R_NONE, R_NONE);
    add_row(8'hFF, 1'b1, 2, '{8'hFF, KIND_DATA, 1'b0}, R_END, R_NONE);
    // named escapes
    add_row(CH_BSLASH, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_N, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_BSLASH, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_R, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_BSLASH, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_T, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_BSLASH, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_QUOTE, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_BSLASH, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_BSLASH, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_BSLASH, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_APOS, 1'b1, PREDICT, R_NONE, R_NONE, R_NONE);
    // 0400 wraps to zero data, not an error
    add_row(CH_BSLASH, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_DIGIT_0 + 8'd4, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_DIGIT_0, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_DIGIT_0, 1'b0, 1, '{8'd0, KIND_DATA, 1'b0}, R_NONE, R_NONE);
    // digit 9 stops the prefix: null octal, then the rest is swallowed
    add_row(CH_BSLASH, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_DIGIT_8 + 8'd1, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_X, 1'b1, 2, '{8'd0, KIND_NULL_OCTAL, 1'b0}, R_END, R_NONE);
    // unknown escape on the last word
    add_row(CH_BSLASH, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_Q, 1'b1, 2, '{8'd0, KIND_BAD_ESCAPE, 1'b0}, R_END, R_NONE);
    // lone trailing backslash
    add_row(CH_BSLASH, 1'b1, 1, R_END, R_NONE, R_NONE);
    // short octal closed by end of string
    add_row(CH_BSLASH, 1'b0, PREDICT, R_NONE, R_NONE, R_NONE);
    add_row(CH_DIGIT_0 + 8'd5, 1'b1, PREDICT, R_NONE, R_NONE, R_NONE);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].b, dir_rows[i].l, dir_rows[i].note);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          hold_req     = 1'b1;
        end
        1: begin
          tx_idle_pct  = 77;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 77;
        end
        default: begin
          tx_idle_pct  = 27;
          rx_stall_pct = 27;
        end
      endcase
      target = live_words + PHASE_WORDS;
      while (live_words < target) send_random_string();
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
